/* rtl/lrl_pkg.sv */
package lrl_pkg;

  localparam int unsigned LIMIT_W   = 4;
  localparam int unsigned WINDOW_W  = 16;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned THR_W     = 40;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 8'd1;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 4'd5;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd10;

  typedef struct packed {
    logic limited;
    logic untracked;
    logic [COUNT_W-1:0] window_count;
  } result_t;

endpackage

/* rtl/lrl_ram.sv */
module lrl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/per_client_sliding_window_limiter.sv */
// Per-client sliding-window rate limiter. Each request (client address, tick
// stamp) gives one result: limited, untracked (new client, table full) and the
// stamps held for the client. Clients fill table entries in arrival order, so a
// request scans the stored keys one per cycle up to its match or up to the
// number of clients held. For a known client the stamp memory is then read from
// the oldest stamp on: the expired ones are read and dropped, plus one more read
// when a live stamp is left. A new client needs no stamp reads. The key scan, over
// up to CLIENTS stored keys, dominates. One request is worked at a time; a new
// one is taken while the last result waits, and its own result then holds in the
// final state until the output frees.
module per_client_sliding_window_limiter #(
  parameter int unsigned CLIENTS          = 256,
  parameter int unsigned MAX_STAMPS       = 8,
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lrl_pkg::IN_DATA_W-1:0]     in_tdata,   // client_address, now_ticks
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lrl_pkg::OUT_DATA_W-1:0]    out_tdata,  // window_count, zero fill
  output logic [lrl_pkg::OUT_USER_W-1:0]    out_tuser,  // limited, untracked
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrl_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import lrl_pkg::*;

  localparam int unsigned CIW = $clog2(CLIENTS);
  localparam int unsigned FW  = $clog2(CLIENTS + 1);
  localparam int unsigned HW  = (MAX_STAMPS > 1) ? $clog2(MAX_STAMPS) : 1;
  localparam int unsigned CW  = $clog2(MAX_STAMPS + 1);
  localparam int unsigned SD  = CLIENTS * MAX_STAMPS;
  localparam int unsigned SAW = $clog2(SD);
  localparam int unsigned MW  = HW + CW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_META, S_EXP, S_DECIDE, S_NEW, S_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [LIMIT_W-1:0]   request_limit_r;
  logic [WINDOW_W-1:0]  window_seconds_r;
  logic [FW-1:0]        fill_r;
  logic [CIW-1:0]       scan_r, hit_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [TICK_W-1:0]    now_r;
  logic [THR_W-1:0]     thr_r;
  logic [CW-1:0]        limit_r, limit_sat;
  logic [HW-1:0]        head_r, head_next;
  logic [CW-1:0]        cnt_r;
  result_t              pend_r;
  result_t              res_r;
  logic                 out_valid_r;

  logic                 key_we, meta_we, stamp_we;
  logic [CIW-1:0]       key_waddr, key_raddr, meta_waddr;
  logic [ADDR_W-1:0]    key_rdata;
  logic [MW-1:0]        meta_wdata, meta_rdata;
  logic [SAW-1:0]       stamp_waddr, stamp_raddr, stamp_base, new_base;
  logic [TICK_W-1:0]    stamp_rdata, age;
  logic [HW-1:0]        meta_head, pos;
  logic [CW-1:0]        meta_cnt, cnt_sat;
  logic [HW:0]          pos_sum;
  logic                 in_acc, last_scan, fresh;

  lrl_ram #(.WIDTH(ADDR_W), .DEPTH(CLIENTS)) u_key (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(addr_r),
    .raddr(key_raddr), .rdata(key_rdata)
  );
  lrl_ram #(.WIDTH(MW), .DEPTH(CLIENTS)) u_meta (
    .clk, .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(scan_r), .rdata(meta_rdata)
  );
  lrl_ram #(.WIDTH(TICK_W), .DEPTH(SD)) u_stamp (
    .clk, .we(stamp_we), .waddr(stamp_waddr), .wdata(now_r),
    .raddr(stamp_raddr), .rdata(stamp_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(res_r.window_count);
  assign out_tuser  = {res_r.untracked, res_r.limited};

  assign meta_head  = meta_rdata[MW-1:CW];
  assign meta_cnt   = meta_rdata[CW-1:0];
  assign cnt_sat    = (32'(meta_cnt) > 32'(MAX_STAMPS)) ? CW'(MAX_STAMPS) : meta_cnt;
  assign limit_sat  = (32'(request_limit_r) > 32'(MAX_STAMPS)) ?
                      CW'(MAX_STAMPS) : CW'(request_limit_r);
  assign head_next  = (32'(head_r) + 32'd1 >= 32'(MAX_STAMPS)) ? '0 : head_r + HW'(1);
  assign pos_sum    = (HW + 1)'(head_r) + (HW + 1)'(cnt_r);
  assign pos        = (32'(pos_sum) >= 32'(MAX_STAMPS)) ?
                      HW'(32'(pos_sum) - 32'(MAX_STAMPS)) : HW'(pos_sum);
  assign stamp_base = SAW'(hit_r) * SAW'(MAX_STAMPS);
  assign new_base   = SAW'(fill_r) * SAW'(MAX_STAMPS);
  assign age        = now_r - stamp_rdata;
  assign last_scan  = (FW'(scan_r) + FW'(1) == fill_r);
  assign fresh      = (THR_W'(age) < thr_r);

  always_comb begin
    key_raddr   = (state_r == S_SCAN) ? scan_r + CIW'(1) : '0;
    stamp_raddr = (state_r == S_META) ? stamp_base + SAW'(meta_head)
                                      : stamp_base + SAW'(head_next);
    key_we      = 1'b0;
    key_waddr   = CIW'(fill_r);
    meta_we     = 1'b0;
    meta_waddr  = hit_r;
    meta_wdata  = {head_r, cnt_r};
    stamp_we    = 1'b0;
    stamp_waddr = stamp_base + SAW'(pos);
    if (state_r == S_DECIDE) begin
      meta_we  = 1'b1;
      stamp_we = (cnt_r < limit_r);
      if (cnt_r < limit_r) begin
        meta_wdata = {head_r, cnt_r + CW'(1)};
      end
    end else if (state_r == S_NEW && fill_r != FW'(CLIENTS)) begin
      key_we      = 1'b1;
      meta_we     = 1'b1;
      meta_waddr  = CIW'(fill_r);
      meta_wdata  = {HW'(0), CW'(1)};
      stamp_we    = 1'b1;
      stamp_waddr = new_base;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (fill_r == '0) ? S_NEW : S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_rdata == addr_r) begin
          state_nxt = S_META;
        end else if (last_scan) begin
          state_nxt = S_NEW;
        end
      end
      S_META:   state_nxt = (cnt_sat == '0) ? S_DECIDE : S_EXP;
      S_EXP: begin
        if (fresh || cnt_r == CW'(1)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: state_nxt = S_FIN;
      S_NEW:    state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      fill_r           <= '0;
      out_valid_r      <= 1'b0;
      request_limit_r  <= LIMIT_RESET;
      window_seconds_r <= WINDOW_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_REQUEST_LIMIT) begin
          request_limit_r <= cfg_data[LIMIT_W-1:0];
        end else if (cfg_index == REG_WINDOW_SECONDS) begin
          window_seconds_r <= cfg_data[WINDOW_W-1:0];
        end
      end
      if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            addr_r  <= in_tdata[ADDR_W-1:0];
            now_r   <= in_tdata[ADDR_W +: TICK_W];
            thr_r   <= (THR_W'(window_seconds_r) + THR_W'(1)) * THR_W'(TICKS_PER_SECOND);
            limit_r <= limit_sat;
            scan_r  <= '0;
          end
        end
        S_SCAN: begin
          if (key_rdata == addr_r) begin
            hit_r <= scan_r;
          end else if (!last_scan) begin
            scan_r <= scan_r + CIW'(1);
          end
        end
        S_META: begin
          head_r <= meta_head;
          cnt_r  <= cnt_sat;
        end
        S_EXP: begin
          if (!fresh) begin
            head_r <= head_next;
            cnt_r  <= cnt_r - CW'(1);
          end
        end
        S_DECIDE: begin
          pend_r.limited   <= (cnt_r >= limit_r);
          pend_r.untracked <= 1'b0;
          pend_r.window_count <= (cnt_r >= limit_r) ? COUNT_W'(cnt_r)
                                                    : COUNT_W'(cnt_r + CW'(1));
        end
        S_NEW: begin
          pend_r.limited <= 1'b0;
          if (fill_r == FW'(CLIENTS)) begin
            pend_r.untracked    <= 1'b1;
            pend_r.window_count <= '0;
          end else begin
            pend_r.untracked    <= 1'b0;
            pend_r.window_count <= COUNT_W'(1);
            fill_r              <= fill_r + FW'(1);
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            res_r <= pend_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/lrl_checker.sv */
module lrl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_denied_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("denied request flagged untracked");

  a_untracked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 8'd0)
    else $error("untracked request with nonzero count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:4] == 4'd0)
    else $error("count outside field");

endmodule

bind per_client_sliding_window_limiter lrl_checker u_lrl_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lrl_pkg::*;

  localparam int unsigned N_CLIENTS = 256;
  localparam int unsigned N_STAMPS = 8;
  localparam int unsigned TPS = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  per_client_sliding_window_limiter uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // decision model state
  logic [LIMIT_W-1:0] lim_reg;
  logic [WINDOW_W-1:0] win_reg;
  logic [31:0] keys [N_CLIENTS];
  bit used [N_CLIENTS];
  logic [31:0] stamps [N_CLIENTS][N_STAMPS];
  int unsigned head_q [N_CLIENTS];
  int unsigned cnt_q [N_CLIENTS];

  result_t decisions [$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_denied = 0;
  int n_untracked = 0;
  bit burst_on = 1'b1;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
  endtask

  function automatic result_t decide(input logic [31:0] addr, input logic [31:0] now);
    result_t r;
    logic [63:0] thr;
    int unsigned lim, hit, free_i, h, c;
    bit found, have_free;
    logic [31:0] age;
    thr = (64'(win_reg) + 64'd1) * 64'(TPS);
    lim = (lim_reg > N_STAMPS) ? N_STAMPS : lim_reg;
    found = 0; have_free = 0; hit = 0; free_i = 0;
    r = '0;
    for (int i = 0; i < N_CLIENTS; i++) begin
      if (used[i]) begin
        if (!found && keys[i] == addr) begin
          found = 1; hit = i;
        end
      end else if (!have_free) begin
        have_free = 1; free_i = i;
      end
    end
    if (found) begin
      h = head_q[hit]; c = cnt_q[hit];
      while (c > 0) begin
        age = now - stamps[hit][h];
        if (64'(age) < thr) break;
        h = (h + 1) % N_STAMPS; c--;
      end
      if (c >= lim) r.limited = 1'b1;
      else begin
        stamps[hit][(h + c) % N_STAMPS] = now; c++;
      end
      head_q[hit] = h; cnt_q[hit] = c;
      r.window_count = COUNT_W'(c);
    end else if (have_free) begin
      used[free_i] = 1; keys[free_i] = addr; head_q[free_i] = 0; cnt_q[free_i] = 1;
      stamps[free_i][0] = now;
      r.window_count = COUNT_W'(1);
    end else begin
      r.untracked = 1'b1;
    end
    return r;
  endfunction

  task automatic send_request(input logic [31:0] addr, input logic [31:0] now);
    if (!burst_on || $urandom_range(0, 9) == 0) begin
      burst_on = 1'b1;
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    if ($urandom_range(0, 11) == 0) burst_on = 1'b0;
    in_tvalid <= 1'b1;
    in_tdata <= {now, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decisions = {decisions, decide(addr, now)};
    n_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (decisions.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_REQUEST_LIMIT) lim_reg = val[LIMIT_W-1:0];
    else if (idx == REG_WINDOW_SECONDS) win_reg = val;
  endtask

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 0);
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (decisions.size() == 0) begin
        report("unexpected result", out_tdata, 0);
      end else begin
        e = decisions[0];
        decisions.delete(0);
        n_checked++;
        if (e.limited) n_denied++;
        if (e.untracked) n_untracked++;
        if (out_tuser[0] !== e.limited) report("limited", out_tuser[0], e.limited);
        if (out_tuser[1] !== e.untracked) report("untracked", out_tuser[1], e.untracked);
        if (out_tdata[COUNT_W-1:0] !== e.window_count)
          report("window_count", out_tdata[COUNT_W-1:0], e.window_count);
        if (out_tdata[OUT_DATA_W-1:COUNT_W] !== '0) report("tdata fill", out_tdata, 0);
      end
    end
  end

  task automatic test_directed;
    send_request(32'h0000_0000, 32'h0000_0000);
    for (int i = 0; i < 7; i++) send_request(32'h0000_0000, 32'(i * 10));
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'h0000_2AF7);
    send_request(32'hFFFF_FFFF, 32'h0000_2AF8);
    send_request(32'h0000_0000, 32'd10999);
    send_request(32'h0000_0000, 32'd11000);
    send_request(32'h0000_0000, 32'd90000);
    write_reg(REG_REQUEST_LIMIT, 16'd0);
    send_request(32'h0000_0000, 32'd90001);
    send_request(32'h1234_5678, 32'd90002);
    write_reg(REG_REQUEST_LIMIT, 16'hFFFF);
    write_reg(REG_WINDOW_SECONDS, 16'hFFFF);
    for (int i = 0; i < 9; i++) send_request(32'hA5A5_5A5A, 32'hFFFF_FFF0 + 32'(i));
    write_reg(REG_WINDOW_SECONDS, 16'd0);
    send_request(32'hA5A5_5A5A, 32'd5000);
    write_reg(8'd2, 16'd3);
    write_reg(8'hFF, 16'd3);
  endtask

  task automatic test_window_sweep;
    logic [31:0] t;
    int unsigned settings [4] = '{1, 3, 8, 15};
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_REQUEST_LIMIT, 16'(settings[s]));
      write_reg(REG_WINDOW_SECONDS, 16'($urandom_range(0, 3)));
      t = $urandom;
      for (int i = 0; i < 90; i++) begin
        t = t + $urandom_range(0, 900);
        if ($urandom_range(0, 9) == 0) t = $urandom;
        send_request($urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(0, 11)), t);
      end
    end
  endtask

  task automatic test_table_full;
    write_reg(REG_REQUEST_LIMIT, 16'd2);
    write_reg(REG_WINDOW_SECONDS, 16'd1);
    for (int i = 0; i < 260; i++) send_request(32'h8000_0000 | 32'(i), 32'(i * 3));
    drain();
    for (int i = 0; i < 24; i++)
      send_request($urandom_range(0, 1) ? 32'h8000_0000 | 32'($urandom_range(0, 300))
                                        : $urandom, $urandom);
  endtask

  initial begin
    lim_reg = LIMIT_RESET;
    win_reg = WINDOW_RESET;
    foreach (used[i]) used[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_window_sweep();
    test_table_full();
    drain();
    $display("sent %0d requests, checked %0d results (%0d denied, %0d untracked)",
             n_sent, n_checked, n_denied, n_untracked);
    $display("covered both register extremes, expiry edges, wrap and a full client table");
    if (errors == 0 && decisions.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb failed");
    $finish;
  end
endmodule
